@@ hdl/scr_pkg.sv @@
// ----------------------------------------------------------------------------
// scr_pkg
// Shared types and constants for the SPI command responder: command word
// passed from the front end to the back end, result word, opcodes.
// ----------------------------------------------------------------------------
package scr_pkg;

  // operation codes on the input port
  localparam logic [1:0] OPER_BYTE = 2'd0;
  localparam logic [1:0] OPER_LOAD = 2'd1;
  localparam logic [1:0] OPER_RPM  = 2'd2;

  // frame opcodes (first byte of a frame)
  localparam logic [7:0] OPC_LONG_A = 8'h01;
  localparam logic [7:0] OPC_PAIR   = 8'h02;
  localparam logic [7:0] OPC_LONG_B = 8'h03;
  localparam logic [7:0] OPC_SHORT  = 8'h04;
  localparam logic [7:0] OPC_QUERY  = 8'h05;

  // first reply byte for query and for plain commands
  localparam logic [7:0] RPL_QUERY = 8'h01;
  localparam logic [7:0] RPL_ACK   = 8'h03;

  localparam logic [1:0] QUERY_REPLY_LEN = 2'd3;
  localparam logic [1:0] ACK_REPLY_LEN   = 2'd1;

  // classified operation kind
  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_LOAD,
    KIND_RPM,
    KIND_NONE
  } kind_t;

  // word carried from the front end to the back end
  typedef struct packed {
    kind_t       kind;
    logic [1:0]  byte_len;
    logic [7:0]  rx_byte;
    logic [7:0]  reply_first;
    logic [7:0]  reply_second;
    logic [7:0]  reply_third;
    logic [1:0]  reply_count;
    logic [15:0] rpm;
  } cmd_t;

  // result word
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       command_event;
    logic [7:0] frame_first;
    logic [7:0] frame_second;
    logic [7:0] frame_third;
    logic       load_accepted;
    logic       is_idle;
  } res_t;

  // frame length set by an opening byte, zero for a non-opcode
  function automatic logic [1:0] opcode_length(input logic [7:0] op);
    logic [1:0] len;
    len = 2'd0;
    if (op == OPC_LONG_A || op == OPC_LONG_B) begin
      len = 2'd3;
    end else if (op == OPC_PAIR) begin
      len = 2'd2;
    end else if (op == OPC_SHORT || op == OPC_QUERY) begin
      len = 2'd1;
    end
    return len;
  endfunction

endpackage

@@ hdl/scr_fifo.sv @@
// ----------------------------------------------------------------------------
// scr_fifo
// Small synchronous queue of words with full and empty flags.
// ----------------------------------------------------------------------------
module scr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  // flags and handshakes
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

@@ hdl/scr_front.sv @@
// ----------------------------------------------------------------------------
// scr_front
// Front end: classifies each incoming word and decodes the frame length of
// a received byte taken as an opening opcode.
// ----------------------------------------------------------------------------
module scr_front (
  input  logic               [1:0]  operation,
  input  logic               [7:0]  rx_byte,
  input  logic               [7:0]  host_reply_first,
  input  logic               [7:0]  host_reply_second,
  input  logic               [7:0]  host_reply_third,
  input  logic               [1:0]  host_reply_count,
  input  logic signed        [15:0] feedback_rpm,
  output scr_pkg::cmd_t             cmd
);

  always_comb begin
    cmd              = '0;
    cmd.rx_byte      = rx_byte;
    cmd.byte_len     = scr_pkg::opcode_length(rx_byte);
    cmd.reply_first  = host_reply_first;
    cmd.reply_second = host_reply_second;
    cmd.reply_third  = host_reply_third;
    cmd.reply_count  = host_reply_count;
    cmd.rpm          = unsigned'(feedback_rpm);
    // operation kind
    case (operation)
      scr_pkg::OPER_BYTE: cmd.kind = scr_pkg::KIND_BYTE;
      scr_pkg::OPER_LOAD: cmd.kind = scr_pkg::KIND_LOAD;
      scr_pkg::OPER_RPM:  cmd.kind = scr_pkg::KIND_RPM;
      default:            cmd.kind = scr_pkg::KIND_NONE;
    endcase
  end

endmodule

@@ hdl/scr_back.sv @@
// ----------------------------------------------------------------------------
// scr_back
// Back end: holds frame and reply state, carries out one command word per
// cycle while a word waits and the result queue has room, and produces its result word.
// ----------------------------------------------------------------------------
module scr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  scr_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output scr_pkg::res_t res
);

  logic [7:0]  rx_store [3];
  logic [7:0]  rx_store_next [3];
  logic [1:0]  rx_count;
  logic [1:0]  rx_count_next;
  logic [1:0]  frame_length;
  logic [1:0]  frame_length_next;
  logic [7:0]  reply_store [3];
  logic [7:0]  reply_store_next [3];
  logic [1:0]  reply_count;
  logic [1:0]  reply_count_next;
  logic [1:0]  reply_pointer;
  logic [1:0]  reply_pointer_next;
  logic [15:0] speed_value;
  logic [15:0] speed_value_next;
  logic        handled;
  logic        block_idle;
  logic        take;

  assign take       = cmd_valid && !res_full;
  assign cmd_pop    = take;
  assign res_push   = take;
  assign block_idle = (rx_count == '0) && (reply_count == '0) && (reply_pointer == '0);

  // next state and result for the word at the queue head
  always_comb begin
    rx_store_next      = rx_store;
    rx_count_next      = rx_count;
    frame_length_next  = frame_length;
    reply_store_next   = reply_store;
    reply_count_next   = reply_count;
    reply_pointer_next = reply_pointer;
    speed_value_next   = speed_value;
    handled            = 1'b0;
    res                = '0;
    case (cmd.kind)
      scr_pkg::KIND_BYTE: begin
        // store the byte while the frame has room
        if (rx_count != 2'd3) begin
          rx_store_next[rx_count] = cmd.rx_byte;
          rx_count_next           = rx_count + 2'd1;
        end
        // opening byte sets the length, a non-opcode drops the frame
        if (rx_count_next == 2'd1) begin
          frame_length_next = cmd.byte_len;
          if (cmd.byte_len == 2'd0) begin
            rx_count_next = 2'd0;
            handled       = 1'b1;
          end
        end
        // frame complete: report it and load the reply
        if (!handled && frame_length_next != 2'd0 && rx_count_next >= frame_length_next) begin
          res.frame_first  = rx_store_next[0];
          res.frame_second = (frame_length_next > 2'd1) ? rx_store_next[1] : 8'd0;
          res.frame_third  = (frame_length_next > 2'd2) ? rx_store_next[2] : 8'd0;
          rx_count_next     = 2'd0;
          frame_length_next = 2'd0;
          if (rx_store_next[0] == scr_pkg::OPC_QUERY) begin
            reply_store_next[0] = scr_pkg::RPL_QUERY;
            reply_store_next[1] = speed_value[7:0];
            reply_store_next[2] = speed_value[15:8];
            reply_count_next    = scr_pkg::QUERY_REPLY_LEN;
          end else begin
            reply_store_next[0] = scr_pkg::RPL_ACK;
            reply_store_next[1] = rx_store_next[0];
            reply_store_next[2] = 8'd0;
            reply_count_next    = scr_pkg::ACK_REPLY_LEN;
            res.command_event   = 1'b1;
          end
          reply_pointer_next = 2'd1;
          res.tx_byte        = reply_store_next[0];
          handled            = 1'b1;
        end
        // no frame completed: shift out the next reply byte or end the spent reply
        if (!handled) begin
          if (reply_pointer < reply_count) begin
            res.tx_byte        = reply_store[reply_pointer];
            reply_pointer_next = reply_pointer + 2'd1;
          end else begin
            reply_count_next   = 2'd0;
            reply_pointer_next = 2'd0;
          end
        end
      end
      scr_pkg::KIND_LOAD: begin
        // host reply only taken while idle
        if (block_idle) begin
          reply_store_next[0] = cmd.reply_first;
          reply_store_next[1] = cmd.reply_second;
          reply_store_next[2] = cmd.reply_third;
          reply_count_next    = cmd.reply_count;
          reply_pointer_next  = 2'd0;
          res.load_accepted   = 1'b1;
        end
      end
      scr_pkg::KIND_RPM: begin
        speed_value_next = cmd.rpm;
      end
      default: begin
      end
    endcase
    res.is_idle = (rx_count_next == '0) && (reply_count_next == '0) &&
                  (reply_pointer_next == '0);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count      <= '0;
      frame_length  <= '0;
      reply_count   <= '0;
      reply_pointer <= '0;
      speed_value   <= '0;
    end else if (take) begin
      rx_count      <= rx_count_next;
      frame_length  <= frame_length_next;
      reply_count   <= reply_count_next;
      reply_pointer <= reply_pointer_next;
      speed_value   <= speed_value_next;
    end
  end

  // frame and reply byte stores
  always_ff @(posedge clk) begin
    if (take) begin
      rx_store    <= rx_store_next;
      reply_store <= reply_store_next;
    end
  end

endmodule

@@ hdl/spi_command_responder.sv @@
// ----------------------------------------------------------------------------
// spi_command_responder
// SPI slave command framer and responder: frames received bytes, raises
// command events and shifts out replies; host may load replies and speed.
// ----------------------------------------------------------------------------
// path: a word accepted into the command queue has its result registered in the result queue ahead of the ports
// throughput: one word per cycle while a word waits and the result queue has room
// the command queue and result queue let each side stall on its own
// reset: synchronous rst empties both queues and clears frame, reply and speed
module spi_command_responder #(
  parameter int CMD_DEPTH = 2,
  parameter int RES_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic        [1:0]  operation,
  input  logic        [7:0]  rx_byte,
  input  logic        [7:0]  host_reply_first,
  input  logic        [7:0]  host_reply_second,
  input  logic        [7:0]  host_reply_third,
  input  logic        [1:0]  host_reply_count,
  input  logic signed [15:0] feedback_rpm,
  output logic               empty,
  input  logic               pop,
  output logic        [7:0]  tx_byte,
  output logic               command_event,
  output logic        [7:0]  frame_first,
  output logic        [7:0]  frame_second,
  output logic        [7:0]  frame_third,
  output logic               load_accepted,
  output logic               is_idle
);

  localparam int CMD_W = $bits(scr_pkg::cmd_t);
  localparam int RES_W = $bits(scr_pkg::res_t);

  scr_pkg::cmd_t cmd_in;
  scr_pkg::cmd_t cmd_head;
  logic          cmd_empty;
  logic          cmd_pop;
  scr_pkg::res_t res_in;
  scr_pkg::res_t res_head;
  logic          res_full;
  logic          res_push;

  // classify incoming words
  scr_front u_front (
    .operation         (operation),
    .rx_byte           (rx_byte),
    .host_reply_first  (host_reply_first),
    .host_reply_second (host_reply_second),
    .host_reply_third  (host_reply_third),
    .host_reply_count  (host_reply_count),
    .feedback_rpm      (feedback_rpm),
    .cmd               (cmd_in)
  );

  // queue between front and back end
  scr_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_head),
    .empty (cmd_empty)
  );

  // frame and reply engine
  scr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // result queue toward the consumer
  scr_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_head),
    .empty (empty)
  );

  assign tx_byte       = res_head.tx_byte;
  assign command_event = res_head.command_event;
  assign frame_first   = res_head.frame_first;
  assign frame_second  = res_head.frame_second;
  assign frame_third   = res_head.frame_third;
  assign load_accepted = res_head.load_accepted;
  assign is_idle       = res_head.is_idle;

endmodule

@@ hdl/scr_checker.sv @@
// ----------------------------------------------------------------------------
// scr_checker
// Port-level checks for the SPI command responder, bound to the top level.
// ----------------------------------------------------------------------------
module scr_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [7:0] tx_byte,
  input logic       command_event,
  input logic [7:0] frame_first,
  input logic [7:0] frame_second,
  input logic [7:0] frame_third,
  input logic       load_accepted
);

  // result queue comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // a waiting word's tx_byte and frame_first hold until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(tx_byte) && $stable(frame_first)))
    else $error("waiting result word changed");

  // command events only for plain command opcodes
  a_event_opcode: assert property (@(posedge clk) disable iff (rst)
    (!empty && command_event) |->
      (frame_first == 8'h01 || frame_first == 8'h02 ||
       frame_first == 8'h03 || frame_first == 8'h04))
    else $error("command event with bad opcode");

  // no completed frame means no frame bytes and no event
  a_no_frame: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_first == 8'h00) |->
      (frame_second == 8'h00 && frame_third == 8'h00 && !command_event))
    else $error("frame bytes without a completed frame");

  // an accepted host load sends nothing to the master
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (!empty && load_accepted) |-> (tx_byte == 8'h00 && !command_event))
    else $error("host load word carries transmit data");

endmodule

bind spi_command_responder scr_checker u_scr_checker (
  .clk           (clk),
  .rst           (rst),
  .empty         (empty),
  .pop           (pop),
  .tx_byte       (tx_byte),
  .command_event (command_event),
  .frame_first   (frame_first),
  .frame_second  (frame_second),
  .frame_third   (frame_third),
  .load_accepted (load_accepted)
);

@@ bench/responder_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// responder_tb_pkg
// Stimulus word type and scoreboard for the SPI command responder bench:
// every accepted word updates a private copy of the frame, reply and speed
// state, and every popped result is checked against the oldest prediction.
// ----------------------------------------------------------------------------
package responder_tb_pkg;

  // unused operation code and the master's filler byte
  localparam logic [1:0] OPER_SPARE = 2'd3;
  localparam logic [7:0] DUMMY_BYTE = 8'h00;

  // cap on printed mismatch lines
  localparam int unsigned REPORT_LIMIT = 40;

  // one input word, one field per port
  typedef struct {
    logic [1:0]         operation;
    logic [7:0]         rx_byte;
    logic [7:0]         host_reply_first;
    logic [7:0]         host_reply_second;
    logic [7:0]         host_reply_third;
    logic [1:0]         host_reply_count;
    logic signed [15:0] feedback_rpm;
  } spi_word_t;

  class responder_scoreboard;
    logic [7:0]    rx_store [3];
    logic [1:0]    rx_count;
    logic [1:0]    frame_len;
    logic [7:0]    reply_store [3];
    logic [1:0]    reply_count;
    logic [1:0]    reply_ptr;
    logic [15:0]   speed;
    scr_pkg::res_t expected_q [$];
    int unsigned   errors;
    int unsigned   checked;
    int unsigned   events;
    int unsigned   queries;
    int unsigned   loads_taken;
    int unsigned   drops;

    function new();
      rx_store    = '{default: '0};
      reply_store = '{default: '0};
      rx_count    = '0;
      frame_len   = '0;
      reply_count = '0;
      reply_ptr   = '0;
      speed       = '0;
      errors      = 0;
      checked     = 0;
      events      = 0;
      queries     = 0;
      loads_taken = 0;
      drops       = 0;
    endfunction

    function bit block_idle();
      return rx_count == 2'd0 && reply_count == 2'd0 && reply_ptr == 2'd0;
    endfunction

    // bytes in a frame opened by this byte, zero when it is no opcode
    function logic [1:0] frame_span(logic [7:0] opc);
      case (opc)
        scr_pkg::OPC_LONG_A, scr_pkg::OPC_LONG_B: return 2'd3;
        scr_pkg::OPC_PAIR:                        return 2'd2;
        scr_pkg::OPC_SHORT, scr_pkg::OPC_QUERY:   return 2'd1;
        default:                                  return 2'd0;
      endcase
    endfunction

    // advance the predicted state by one accepted word, queue its result
    function void note_word(spi_word_t w);
      scr_pkg::res_t r;
      bit            done;
      r    = '0;
      done = 1'b0;
      case (w.operation)
        scr_pkg::OPER_BYTE: begin
          // store while room is left
          if (rx_count < 2'd3) begin
            rx_store[rx_count] = w.rx_byte;
            rx_count = rx_count + 2'd1;
          end
          // opening byte decides the frame length, non-opcodes drop the frame
          if (rx_count == 2'd1) begin
            frame_len = frame_span(w.rx_byte);
            if (frame_len == 2'd0) begin
              rx_count = 2'd0;
              done = 1'b1;
              drops++;
            end
          end
          // frame complete: load the reply and present its first byte
          if (!done && frame_len != 2'd0 && rx_count >= frame_len) begin
            r.frame_first  = rx_store[0];
            r.frame_second = (frame_len > 2'd1) ? rx_store[1] : 8'h00;
            r.frame_third  = (frame_len > 2'd2) ? rx_store[2] : 8'h00;
            rx_count  = 2'd0;
            frame_len = 2'd0;
            if (r.frame_first == scr_pkg::OPC_QUERY) begin
              reply_store = '{scr_pkg::RPL_QUERY, speed[7:0], speed[15:8]};
              reply_count = scr_pkg::QUERY_REPLY_LEN;
              queries++;
            end else begin
              reply_store = '{scr_pkg::RPL_ACK, r.frame_first, 8'h00};
              reply_count = scr_pkg::ACK_REPLY_LEN;
              r.command_event = 1'b1;
              events++;
            end
            reply_ptr = 2'd1;
            r.tx_byte = reply_store[0];
            done = 1'b1;
          end
          // mid-frame byte shifts out the next reply byte or ends the reply
          if (!done) begin
            if (reply_ptr < reply_count) begin
              r.tx_byte = reply_store[reply_ptr];
              reply_ptr = reply_ptr + 2'd1;
            end else begin
              reply_count = 2'd0;
              reply_ptr   = 2'd0;
            end
          end
        end
        scr_pkg::OPER_LOAD: begin
          // host reply only taken while nothing is in flight
          if (block_idle()) begin
            reply_store = '{w.host_reply_first, w.host_reply_second, w.host_reply_third};
            reply_count = w.host_reply_count;
            reply_ptr   = 2'd0;
            r.load_accepted = 1'b1;
            loads_taken++;
          end
        end
        scr_pkg::OPER_RPM: begin
          speed = w.feedback_rpm;
        end
        default: begin
        end
      endcase
      r.is_idle = block_idle();
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) begin
        $display("MISMATCH: %s", msg);
      end
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
        report($sformatf("result %0d %s got %02h want %02h", checked, name, got, want));
      end
    endtask

    // check one popped result against the oldest prediction
    task check_result(scr_pkg::res_t got);
      scr_pkg::res_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected, tx_byte %02h", got.tx_byte));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      compare_field("tx_byte", got.tx_byte, want.tx_byte);
      compare_field("command_event", 8'(got.command_event), 8'(want.command_event));
      compare_field("frame_first", got.frame_first, want.frame_first);
      compare_field("frame_second", got.frame_second, want.frame_second);
      compare_field("frame_third", got.frame_third, want.frame_third);
      compare_field("load_accepted", 8'(got.load_accepted), 8'(want.load_accepted));
      compare_field("is_idle", 8'(got.is_idle), 8'(want.is_idle));
    endtask

    task check_drained();
      if (expected_q.size() != 0) begin
        report($sformatf("%0d results never arrived", expected_q.size()));
      end
    endtask
  endclass

endpackage

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the SPI command responder: a directed opening that walks the
// idle host loads, dropped opening bytes and every frame opcode, then random
// framed traffic under changing push and pop pressure, all results checked.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned WORD_TARGET = 1050;
  localparam int unsigned CHUNK       = 105;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned TAIL_CYCLES = 8;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               pop = 1'b0;
  logic        [1:0]  operation = '0;
  logic        [7:0]  rx_byte = '0;
  logic        [7:0]  host_reply_first = '0;
  logic        [7:0]  host_reply_second = '0;
  logic        [7:0]  host_reply_third = '0;
  logic        [1:0]  host_reply_count = '0;
  logic signed [15:0] feedback_rpm = '0;
  logic               full;
  logic               empty;
  logic        [7:0]  tx_byte;
  logic               command_event;
  logic        [7:0]  frame_first;
  logic        [7:0]  frame_second;
  logic        [7:0]  frame_third;
  logic               load_accepted;
  logic               is_idle;

  responder_tb_pkg::responder_scoreboard sb;
  int unsigned         send_idle_pct = 0;
  int unsigned         pop_stall_pct = 0;
  bit                  hold_off = 1'b0;
  int unsigned         words_counted = 0;
  int unsigned         full_stalls = 0;

  spi_command_responder uut (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .operation         (operation),
    .rx_byte           (rx_byte),
    .host_reply_first  (host_reply_first),
    .host_reply_second (host_reply_second),
    .host_reply_third  (host_reply_third),
    .host_reply_count  (host_reply_count),
    .feedback_rpm      (feedback_rpm),
    .empty             (empty),
    .pop               (pop),
    .tx_byte           (tx_byte),
    .command_event     (command_event),
    .frame_first       (frame_first),
    .frame_second      (frame_second),
    .frame_third       (frame_third),
    .load_accepted     (load_accepted),
    .is_idle           (is_idle)
  );

  // clock
  always #6 clk = ~clk;

  // run limit
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: pop decided at the falling edge, long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  // result monitor and input stall count
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      sb.check_result(scr_pkg::res_t'{tx_byte, command_event, frame_first, frame_second,
                                      frame_third, load_accepted, is_idle});
    end
    if (!rst && push && full) begin
      full_stalls++;
    end
  end

  // word with every field random
  function automatic responder_tb_pkg::spi_word_t random_word(logic [1:0] op);
    responder_tb_pkg::spi_word_t w;
    w.operation         = op;
    w.rx_byte           = 8'($urandom);
    w.host_reply_first  = 8'($urandom);
    w.host_reply_second = 8'($urandom);
    w.host_reply_third  = 8'($urandom);
    w.host_reply_count  = 2'($urandom);
    w.feedback_rpm      = 16'($urandom);
    return w;
  endfunction

  // offer one word until taken, then maybe leave a gap
  task automatic send_word(responder_tb_pkg::spi_word_t w);
    @(negedge clk);
    push              <= 1'b1;
    operation         <= w.operation;
    rx_byte           <= w.rx_byte;
    host_reply_first  <= w.host_reply_first;
    host_reply_second <= w.host_reply_second;
    host_reply_third  <= w.host_reply_third;
    host_reply_count  <= w.host_reply_count;
    feedback_rpm      <= w.feedback_rpm;
    do @(posedge clk); while (full);
    sb.note_word(w);
    words_counted++;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      push <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
  endtask

  task automatic send_byte(logic [7:0] b);
    responder_tb_pkg::spi_word_t w;
    w = random_word(scr_pkg::OPER_BYTE);
    w.rx_byte = b;
    send_word(w);
  endtask

  task automatic send_rpm(logic [15:0] v);
    responder_tb_pkg::spi_word_t w;
    w = random_word(scr_pkg::OPER_RPM);
    w.feedback_rpm = v;
    send_word(w);
  endtask

  task automatic send_load(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [1:0] n);
    responder_tb_pkg::spi_word_t w;
    w = random_word(scr_pkg::OPER_LOAD);
    w.host_reply_first  = a;
    w.host_reply_second = b;
    w.host_reply_third  = c;
    w.host_reply_count  = n;
    send_word(w);
  endtask

  // opcode byte followed by random frame bytes
  task automatic send_frame(logic [7:0] opc);
    send_byte(opc);
    repeat (int'(sb.frame_span(opc)) - 1) send_byte(8'($urandom));
  endtask

  // mostly well-formed frames, the rest host traffic and noise
  task automatic random_unit();
    int unsigned pick;
    logic [7:0]  opc;
    pick = $urandom_range(99);
    if (pick < 70) begin
      case ($urandom_range(4))
        0:       opc = scr_pkg::OPC_LONG_A;
        1:       opc = scr_pkg::OPC_PAIR;
        2:       opc = scr_pkg::OPC_LONG_B;
        3:       opc = scr_pkg::OPC_SHORT;
        default: opc = scr_pkg::OPC_QUERY;
      endcase
      send_frame(opc);
    end else if (pick < 80) begin
      send_rpm(16'($urandom));
    end else if (pick < 87) begin
      send_byte(8'($urandom));
    end else if (pick < 92) begin
      send_byte(responder_tb_pkg::DUMMY_BYTE);
    end else if (pick < 96) begin
      send_word(random_word(scr_pkg::OPER_LOAD));
    end else begin
      send_word(random_word(responder_tb_pkg::OPER_SPARE));
    end
  endtask

  // stimulus
  initial begin
    int unsigned phase_end;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // idle block: spare code, speed extremes, empty host load, dropped openers
    send_word(random_word(responder_tb_pkg::OPER_SPARE));
    send_rpm(16'h8000);
    send_rpm(16'h7FFF);
    send_load(8'hFF, 8'h00, 8'hFF, 2'd0);
    send_byte(responder_tb_pkg::DUMMY_BYTE);
    send_byte(8'hFF);
    send_byte(8'h06);
    // full host reply, then a load refused while busy
    send_load(8'h00, 8'hFF, 8'hA5, 2'd3);
    send_load(8'h5A, 8'h5A, 8'h5A, 2'd2);
    send_word(random_word(responder_tb_pkg::OPER_SPARE));
    // long frame shifts out the host reply while it fills
    send_byte(scr_pkg::OPC_LONG_A);
    send_byte(8'hFF);
    send_byte(8'h00);
    // each opcode once; the next opener ends a spent reply
    send_frame(scr_pkg::OPC_PAIR);
    send_frame(scr_pkg::OPC_LONG_B);
    send_frame(scr_pkg::OPC_SHORT);
    send_rpm(16'($urandom));
    send_frame(scr_pkg::OPC_QUERY);
    // query reply clocked out by a long frame, dummy leaves it alone
    send_byte(scr_pkg::OPC_LONG_A);
    send_byte(responder_tb_pkg::DUMMY_BYTE);
    send_byte(8'h80);
    send_frame(scr_pkg::OPC_QUERY);
    send_byte(responder_tb_pkg::DUMMY_BYTE);
    send_frame(scr_pkg::OPC_PAIR);

    // random traffic, phases rotate through the idling patterns
    for (int ph = 0; words_counted < WORD_TARGET; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 63; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 63; end
        default: begin send_idle_pct = 25; pop_stall_pct = 25; end
      endcase
      // receiver holds off while the sender keeps pushing into a full block
      if (ph == 4) begin
        hold_off = 1'b1;
      end
      phase_end = words_counted + CHUNK;
      while (words_counted < phase_end && words_counted < WORD_TARGET) begin
        random_unit();
      end
    end

    @(negedge clk);
    push <= 1'b0;
    pop_stall_pct = 0;

    // drain and let the pipeline settle
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.check_drained();

    $display("Run checked %0d results: %0d command events, %0d query replies",
             sb.checked, sb.events, sb.queries);
    $display("Openers dropped: %0d; host loads taken: %0d; cycles held back by full: %0d",
             sb.drops, sb.loads_taken, full_stalls);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
